FILE: rtl/core/gld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_pkg: shared types and tables for the lunar date converter
// Year table rom, solar term offsets, month offsets and datapath structs.
// ----------------------------------------------------------------------------
package gld_pkg;

  // table range and fixed-point constants
  localparam int unsigned FIRST_TABLE_YEAR = 11;
  localparam int unsigned TABLE_YEARS      = 40;
  localparam logic [6:0]  YEAR_LO          = 7'(FIRST_TABLE_YEAR + 1);
  localparam logic [6:0]  YEAR_HI          = 7'(FIRST_TABLE_YEAR + TABLE_YEARS - 1);
  localparam logic [13:0] D_Q16            = 14'd15873;
  localparam logic [4:0]  NO_TERM          = 5'd24;

  localparam int unsigned VW = 10;  // signed width of day counts

  typedef logic signed [VW-1:0] val_t;

  // shared subtract / compare unit response
  typedef struct packed {
    val_t diff;
    logic neg;
    logic zero;
  } alu_rsp_t;

  // solar term check request and response
  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [20:0] yd;
    logic        sel;
  } term_req_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } term_rsp_t;

  // per-year row: {leap month, 13 month size bits, festival code}
  function automatic logic [23:0] year_rom(input logic [5:0] row);
    logic [23:0] w;
    begin
      unique case (row)
        6'd0:  w = 24'h0B4A43;  6'd1:  w = 24'h4B5537;
        6'd2:  w = 24'h0AD54A;  6'd3:  w = 24'h955ABF;
        6'd4:  w = 24'h04BA53;  6'd5:  w = 24'h0A5B48;
        6'd6:  w = 24'h652BBC;  6'd7:  w = 24'h052B50;
        6'd8:  w = 24'h0A9345;  6'd9:  w = 24'h474AB9;
        6'd10: w = 24'h06AA4C;  6'd11: w = 24'h0AD541;
        6'd12: w = 24'h24DAB6;  6'd13: w = 24'h04B64A;
        6'd14: w = 24'h69573D;  6'd15: w = 24'h0A4E51;
        6'd16: w = 24'h0D2646;  6'd17: w = 24'h5E933A;
        6'd18: w = 24'h0D534D;  6'd19: w = 24'h05AA43;
        6'd20: w = 24'h36B537;  6'd21: w = 24'h096D4B;
        6'd22: w = 24'hB4AEBF;  6'd23: w = 24'h04AD53;
        6'd24: w = 24'h0A4D48;  6'd25: w = 24'h6D25BC;
        6'd26: w = 24'h0D254F;  6'd27: w = 24'h0D5244;
        6'd28: w = 24'h5DAA38;  6'd29: w = 24'h0B5A4C;
        6'd30: w = 24'h056D41;  6'd31: w = 24'h24ADB6;
        6'd32: w = 24'h049B4A;  6'd33: w = 24'h7A4BBE;
        6'd34: w = 24'h0A4B51;  6'd35: w = 24'h0AA546;
        6'd36: w = 24'h5B52BA;  6'd37: w = 24'h06D24E;
        6'd38: w = 24'h0ADA42;  6'd39: w = 24'h355B37;
        default: w = 24'h000000;
      endcase
      return w;
    end
  endfunction

  // term offset C in q16
  function automatic logic [20:0] term_c(input logic [4:0] idx);
    logic [20:0] c;
    begin
      unique case (idx)
        5'd0:  c = 21'd354255;  5'd1:  c = 21'd1318584;
        5'd2:  c = 21'd253624;  5'd3:  c = 21'd1227489;
        5'd4:  c = 21'd368968;  5'd5:  c = 21'd1353056;
        5'd6:  c = 21'd315228;  5'd7:  c = 21'd1317274;
        5'd8:  c = 21'd361759;  5'd9:  c = 21'd1378877;
        5'd10: c = 21'd372113;  5'd11: c = 21'd1400504;
        5'd12: c = 21'd465830;  5'd13: c = 21'd1496187;
        5'd14: c = 21'd491520;  5'd15: c = 21'd1515848;
        5'd16: c = 21'd501088;  5'd17: c = 21'd1510081;
        5'd18: c = 21'd545128;  5'd19: c = 21'd1536033;
        5'd20: c = 21'd487457;  5'd21: c = 21'd1465385;
        5'd22: c = 21'd470548;  5'd23: c = 21'd1437860;
        default: c = 21'd0;
      endcase
      return c;
    end
  endfunction

  // published per-year term corrections
  function automatic logic signed [7:0] term_fix(input logic [6:0] y, input logic [4:0] i);
    logic signed [7:0] f;
    begin
      unique case ({y, i})
        {7'd26, 5'd3}:  f = -8'sd1;
        {7'd84, 5'd5}:  f = 8'sd1;
        {7'd8,  5'd9}:  f = 8'sd1;
        {7'd16, 5'd12}: f = 8'sd1;
        {7'd2,  5'd14}: f = 8'sd1;
        {7'd89, 5'd19}: f = 8'sd1;
        {7'd89, 5'd20}: f = 8'sd1;
        {7'd21, 5'd23}: f = -8'sd1;
        {7'd19, 5'd0}:  f = -8'sd1;
        {7'd82, 5'd1}:  f = 8'sd1;
        default:        f = 8'sd0;
      endcase
      return f;
    end
  endfunction

  // days before the first of each month, non-leap year
  function automatic logic [8:0] days_before(input logic [3:0] mi);
    logic [8:0] n;
    begin
      unique case (mi)
        4'd0:  n = 9'd0;   4'd1:  n = 9'd31;  4'd2:  n = 9'd59;
        4'd3:  n = 9'd90;  4'd4:  n = 9'd120; 4'd5:  n = 9'd151;
        4'd6:  n = 9'd181; 4'd7:  n = 9'd212; 4'd8:  n = 9'd243;
        4'd9:  n = 9'd273; 4'd10: n = 9'd304; 4'd11: n = 9'd334;
        default: n = 9'd0;
      endcase
      return n;
    end
  endfunction

  // size of lunar month slot p (29 or 30 days)
  function automatic val_t slot_size(input logic [23:0] w, input logic [3:0] p);
    logic [12:0] bits;
    logic [3:0]  bi;
    begin
      bits = {w[19:8], w[7]};
      bi   = 4'd12 - p;
      return val_t'(VW'(29) + VW'(bits[bi]));
    end
  endfunction

  // last slot index: 12 with a leap month, 11 without
  function automatic logic [3:0] last_slot(input logic [23:0] w);
    return (w[23:20] != 4'd0) ? 4'd12 : 4'd11;
  endfunction

endpackage

FILE: rtl/core/gregorian_to_lunar_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit: gregorian date to chinese lunar date
// Sequencer around a shared subtract unit that walks lunar months one per
// cycle, plus a solar term check of the two terms of the given month.
// ----------------------------------------------------------------------------
// sequence: setup, two term checks, then the result when out of table range; in range
//   also direction and one step per month slot checked before the result
// a new date is taken only in idle; busy while converting
// a new date is taken while a finished result still waits on the output
// reset: synchronous active-low rst_n clears the sequencer and output valid
module gregorian_to_lunar_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // greg_year[6:0], greg_month[10:7], greg_day[15:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // moon_month[3:0], moon_day[8:4], is_leap_month[9],
                                  // term_index[14:10], out_of_range[15]
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TERM0, S_TERM1, S_DIR, S_BACK0, S_FWD, S_BWD, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [6:0]        year_r, year_nxt;
  logic [3:0]        month_r, month_nxt;
  logic [4:0]        day_r, day_nxt;
  logic              oor_r, oor_nxt;
  gld_pkg::val_t     doy_r, doy_nxt;
  gld_pkg::val_t     fest_r, fest_nxt;
  gld_pkg::val_t     iv_r, iv_nxt;
  logic [23:0]       cur_word_r, cur_word_nxt;
  logic [23:0]       prev_word_r, prev_word_nxt;
  logic [20:0]       yd_r, yd_nxt;
  logic [4:0]        term_r, term_nxt;
  logic              fwd_r, fwd_nxt;
  logic [3:0]        p_r, p_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [15:0]       out_tdata_r, out_tdata_nxt;

  gld_pkg::val_t     alu_a, alu_b;
  gld_pkg::alu_rsp_t alu_rsp;
  gld_pkg::term_req_t term_req;
  gld_pkg::term_rsp_t term_rsp;

  logic [23:0]       walk_word;
  gld_pkg::val_t     size_p;
  logic [3:0]        last_p;
  logic [3:0]        mc;
  logic [3:0]        lm;
  logic [3:0]        lab_month;
  logic              lab_leap;
  logic [4:0]        day_sat;
  logic              out_free;

  // shared subtract unit
  gld_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp)
  );

  // solar term check, one candidate per cycle
  assign term_req.year  = year_r;
  assign term_req.month = month_r;
  assign term_req.day   = day_r;
  assign term_req.yd    = yd_r;
  assign term_req.sel   = (state_r == S_TERM1);

  gld_term u_term (
    .req (term_req),
    .rsp (term_rsp)
  );

  // walk operands from this or the previous lunar year
  assign walk_word = fwd_r ? cur_word_r : prev_word_r;
  assign size_p    = gld_pkg::slot_size(walk_word, p_r);
  assign last_p    = gld_pkg::last_slot(walk_word);
  assign out_free  = !out_tvalid_r || out_tready;

  // clamped month for the day-of-year count
  always_comb begin
    if (month_r == 4'd0) begin
      mc = 4'd1;
    end else if (month_r > 4'd12) begin
      mc = 4'd12;
    end else begin
      mc = month_r;
    end
  end

  // month label of the slot reached
  assign lm = walk_word[23:20];
  always_comb begin
    if (lm == 4'd0 || p_r < lm) begin
      lab_month = p_r + 4'd1;
      lab_leap  = 1'b0;
    end else if (p_r == lm) begin
      lab_month = lm;
      lab_leap  = 1'b1;
    end else begin
      lab_month = p_r;
      lab_leap  = 1'b0;
    end
  end

  // final day, saturated to 1..30
  always_comb begin
    if (alu_rsp.neg || alu_rsp.zero) begin
      day_sat = 5'd1;
    end else if (alu_rsp.diff > gld_pkg::val_t'(30)) begin
      day_sat = 5'd30;
    end else begin
      day_sat = alu_rsp.diff[4:0];
    end
  end

  // sequencer next state and datapath
  always_comb begin
    state_nxt      = state_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    oor_nxt        = oor_r;
    doy_nxt        = doy_r;
    fest_nxt       = fest_r;
    iv_nxt         = iv_r;
    cur_word_nxt   = cur_word_r;
    prev_word_nxt  = prev_word_r;
    yd_nxt         = yd_r;
    term_nxt       = term_r;
    fwd_nxt        = fwd_r;
    p_nxt          = p_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    alu_a          = iv_r;
    alu_b          = size_p;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          year_nxt  = in_tdata[6:0];
          month_nxt = in_tdata[10:7];
          day_nxt   = in_tdata[15:11];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        oor_nxt       = !(year_r >= gld_pkg::YEAR_LO && year_r <= gld_pkg::YEAR_HI);
        doy_nxt       = gld_pkg::val_t'(gld_pkg::days_before(mc - 4'd1))
                        + gld_pkg::val_t'(day_r) - gld_pkg::val_t'(1)
                        + gld_pkg::val_t'((mc > 4'd2) && (year_r[1:0] == 2'b00));
        cur_word_nxt  = gld_pkg::year_rom(6'(year_r - 7'(gld_pkg::FIRST_TABLE_YEAR)));
        prev_word_nxt = gld_pkg::year_rom(6'(year_r - 7'(gld_pkg::FIRST_TABLE_YEAR + 1)));
        if (cur_word_nxt[6:5] == 2'b01) begin
          fest_nxt = gld_pkg::val_t'(cur_word_nxt[4:0]) - gld_pkg::val_t'(1);
        end else begin
          fest_nxt = gld_pkg::val_t'(cur_word_nxt[4:0]) + gld_pkg::val_t'(30);
        end
        yd_nxt    = 21'(year_r * gld_pkg::D_Q16);
        term_nxt  = gld_pkg::NO_TERM;
        state_nxt = S_TERM0;
      end
      S_TERM0: begin
        if (term_rsp.hit) begin
          term_nxt = term_rsp.idx;
        end
        state_nxt = S_TERM1;
      end
      S_TERM1: begin
        if (term_rsp.hit && term_r == gld_pkg::NO_TERM) begin
          term_nxt = term_rsp.idx;
        end
        state_nxt = oor_r ? S_FIN : S_DIR;
      end
      S_DIR: begin
        alu_a = doy_r;
        alu_b = fest_r;
        p_nxt = 4'd0;
        if (!alu_rsp.neg) begin
          fwd_nxt   = 1'b1;
          iv_nxt    = alu_rsp.diff;
          state_nxt = S_FWD;
        end else begin
          fwd_nxt   = 1'b0;
          state_nxt = S_BACK0;
        end
      end
      S_BACK0: begin
        alu_a     = fest_r;
        alu_b     = doy_r;
        iv_nxt    = alu_rsp.diff;
        p_nxt     = gld_pkg::last_slot(prev_word_r);
        state_nxt = S_BWD;
      end
      S_FWD: begin
        if (p_r < last_p && !alu_rsp.neg) begin
          iv_nxt = alu_rsp.diff;
          p_nxt  = p_r + 4'd1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BWD: begin
        if (p_r != 4'd0 && !alu_rsp.neg && !alu_rsp.zero) begin
          iv_nxt = alu_rsp.diff;
          p_nxt  = p_r - 4'd1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // forward: iv + 1, backward: size + 1 - iv
        alu_a = fwd_r ? iv_r : size_p + gld_pkg::val_t'(1);
        alu_b = fwd_r ? gld_pkg::val_t'(-1) : iv_r;
        if (out_free) begin
          if (oor_r) begin
            out_tdata_nxt = {1'b1, term_r, 1'b0, 5'd0, 4'd0};
          end else begin
            out_tdata_nxt = {1'b0, term_r, lab_leap, day_sat, lab_month};
          end
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    oor_r       <= oor_nxt;
    doy_r       <= doy_nxt;
    fest_r      <= fest_nxt;
    iv_r        <= iv_nxt;
    cur_word_r  <= cur_word_nxt;
    prev_word_r <= prev_word_nxt;
    yd_r        <= yd_nxt;
    term_r      <= term_nxt;
    fwd_r       <= fwd_nxt;
    p_r         <= p_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  // month walk never leaves the thirteen slots
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD || state_r == S_BWD) |-> (p_r <= 4'd12))
    else $error("lunar month slot index out of range");

  // out of range beats carry a zero lunar date
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[15]) |-> (out_tdata_r[9:0] == 10'd0))
    else $error("out of range result with nonzero lunar date");

  // in range beats carry a real lunar date
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[15]) |->
      (out_tdata_r[8:4] >= 5'd1 && out_tdata_r[8:4] <= 5'd30 && out_tdata_r[3:0] != 4'd0))
    else $error("lunar day or month out of range");

  // a new result is only loaded after the previous one was taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_tvalid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result loaded over a pending beat");
`endif

endmodule

FILE: rtl/core/gld_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_alu: shared subtract and compare unit
// One signed subtraction per cycle with sign and zero flags for the walk.
// ----------------------------------------------------------------------------
module gld_alu (
  input  gld_pkg::val_t     a,
  input  gld_pkg::val_t     b,
  output gld_pkg::alu_rsp_t rsp
);

  gld_pkg::val_t diff;

  // a - b and its flags
  assign diff     = a - b;
  assign rsp.diff = diff;
  assign rsp.neg  = diff[gld_pkg::VW-1];
  assign rsp.zero = (diff == '0);

endmodule

FILE: rtl/core/gld_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_term: solar term day check
// Computes the day of one candidate term of the month and matches the date.
// ----------------------------------------------------------------------------
module gld_term (
  input  gld_pkg::term_req_t req,
  output gld_pkg::term_rsp_t rsp
);

  logic [4:0]        idx;
  logic [21:0]       sum;
  logic [7:0]        yp3;
  logic signed [7:0] leaps;
  logic signed [7:0] day_c;
  logic              month_ok;

  // candidate index: two terms per month, first or second
  assign idx      = {req.month - 4'd1, req.sel};
  assign month_ok = (req.month >= 4'd1) && (req.month <= 4'd12);

  // floor(y*d + c) in q16
  assign sum = {1'b0, req.yd} + {1'b0, gld_pkg::term_c(idx)};

  // leap years before the term; january and february terms use y-1
  assign yp3 = {1'b0, req.year} + 8'd3;
  always_comb begin
    if (idx < 5'd4) begin
      leaps = $signed({2'b00, yp3[7:2]}) - 8'sd1;
    end else begin
      leaps = $signed({3'b000, req.year[6:2]});
    end
  end

  assign day_c = $signed({2'b00, sum[21:16]}) - leaps + gld_pkg::term_fix(req.year, idx);

  assign rsp.hit = month_ok && (day_c == $signed({3'b000, req.day}));
  assign rsp.idx = idx;

endmodule
